@@ sv/deq_pkg.sv @@
// Shared operation codes and sequencer state type for the bounded deque.
package deq_pkg;

    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_SEARCH     = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } t_state;

endpackage

@@ sv/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bounded_deque_with_search_unit.sv @@
// Top level of the bounded double-ended queue with membership search.
//
// A bounded deque of up to DEPTH signed 32-bit values held in one RAM as a
// circular buffer, tracked by a head index and a fill count. Each input
// transfer carries an operation: push front, push back, pop front, pop back
// or search. Every input transfer yields exactly one result transfer with ok
// (push or pop took effect), found (search hit) and count (fill count after
// the operation, low 5 bits). Pushes into a full queue and pops from an empty
// one report ok = 0 and change nothing; unused operation codes do nothing.
// Timing: a push or pop result is registered and presented in the cycle after
// its transfer. A search walks the entries front to back through the
// single RAM read port, one entry per cycle into one shared 32-bit equality
// comparator, and stops at the first hit; its result is registered once the
// hit is compared or, on a miss, once every entry has been compared. The
// input is not ready while a search runs. The store needs no clearing pass
// after reset, since only slots written by a push are ever read. The result
// register lets the next item be taken in the same cycle that the pending
// result is taken.
module bounded_deque_with_search_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic signed [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic        o_found,
    output logic [4:0]  o_count
);

    localparam int HW = $clog2(DEPTH);      // slot index width
    localparam int CW = $clog2(DEPTH + 1);  // fill count / cursor width
    localparam int SW = CW + 1;             // head + offset sum width

    t_state r_state, n_state;

    logic [HW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_cursor, n_cursor;
    logic          r_cmp_pend, n_cmp_pend;
    logic [31:0]   r_key, n_key;

    logic          r_out_valid, n_out_valid;
    logic          r_ok, n_ok;
    logic          r_found, n_found;
    logic [4:0]    r_count, n_count;

    logic          w_in_xfer;
    logic          w_issue;
    logic          w_match;
    logic          w_search_done;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_offset;
    logic [SW-1:0] w_sum;
    logic [HW-1:0] w_slot;
    logic [HW-1:0] w_head_dec;
    logic [HW-1:0] w_head_inc;
    logic          w_we;
    logic [HW-1:0] w_waddr;
    logic [31:0]   w_rdata;
    logic [31:0]   w_fill_ext;

    assign w_full  = (r_fill == CW'(DEPTH));
    assign w_empty = (r_fill == '0);

    // Shared slot adder: head plus search cursor while searching, else plus fill.
    assign w_offset = (r_state == ST_SEARCH) ? r_cursor : r_fill;
    assign w_sum    = SW'(r_head) + SW'(w_offset);
    always_comb begin
        if (w_sum >= SW'(DEPTH)) begin
            w_slot = HW'(w_sum - SW'(DEPTH));
        end else begin
            w_slot = HW'(w_sum);
        end
    end

    assign w_head_dec = (r_head == '0) ? HW'(DEPTH - 1) : r_head - HW'(1);
    assign w_head_inc = (r_head == HW'(DEPTH - 1)) ? '0 : r_head + HW'(1);

    // Shared comparator on the registered RAM read data.
    assign w_match = (w_rdata == r_key);

    // Sequencer outputs.
    always_comb begin
        o_ready       = 1'b0;
        w_issue       = 1'b0;
        w_search_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = !r_out_valid || i_ready;
            end
            ST_SEARCH: begin
                w_issue       = (r_cursor < r_fill);
                w_search_done = (r_cmp_pend && (w_match || !w_issue)) ||
                                (!r_cmp_pend && !w_issue);
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_in_xfer = i_valid && o_ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (i_func == FUNC_SEARCH)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_search_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store write: new front slot or the slot past the back.
    assign w_we    = w_in_xfer && !w_full &&
                     ((i_func == FUNC_PUSH_FRONT) || (i_func == FUNC_PUSH_BACK));
    assign w_waddr = (i_func == FUNC_PUSH_FRONT) ? w_head_dec : w_slot;

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    // Datapath next values.
    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        n_cursor    = r_cursor;
        n_cmp_pend  = r_cmp_pend;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_found     = r_found;
        n_count     = r_count;

        // Drop the result once it is taken.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_in_xfer) begin
            n_ok    = 1'b0;
            n_found = 1'b0;
            priority if (i_func == FUNC_SEARCH) begin
                n_cursor   = '0;
                n_cmp_pend = 1'b0;
                n_key      = i_value;
            end else if (i_func == FUNC_PUSH_FRONT) begin
                if (!w_full) begin
                    n_head = w_head_dec;
                    n_fill = r_fill + CW'(1);
                    n_ok   = 1'b1;
                end
            end else if (i_func == FUNC_PUSH_BACK) begin
                if (!w_full) begin
                    n_fill = r_fill + CW'(1);
                    n_ok   = 1'b1;
                end
            end else if (i_func == FUNC_POP_FRONT) begin
                if (!w_empty) begin
                    n_head = w_head_inc;
                    n_fill = r_fill - CW'(1);
                    n_ok   = 1'b1;
                end
            end else if (i_func == FUNC_POP_BACK) begin
                if (!w_empty) begin
                    n_fill = r_fill - CW'(1);
                    n_ok   = 1'b1;
                end
            end else begin
                n_ok = 1'b0;
            end
            if (i_func != FUNC_SEARCH) begin
                n_out_valid = 1'b1;
            end
        end

        if (r_state == ST_SEARCH) begin
            // Advance the cursor; the compare lands in the cycle after the read.
            if (w_issue) begin
                n_cursor = r_cursor + CW'(1);
            end
            n_cmp_pend = w_issue;
            if (w_search_done) begin
                n_ok        = 1'b0;
                n_found     = r_cmp_pend && w_match;
                n_out_valid = 1'b1;
                n_cmp_pend  = 1'b0;
            end
        end

        if (n_out_valid && !(r_out_valid && !i_ready)) begin
            n_count = w_fill_ext[4:0];
        end
    end

    assign w_fill_ext = 32'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_cursor    <= n_cursor;
            r_cmp_pend  <= n_cmp_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_ok    <= n_ok;
        r_found <= n_found;
        r_count <= n_count;
    end

    assign o_valid = r_out_valid;
    assign o_ok    = r_ok;
    assign o_found = r_found;
    assign o_count = r_count;

endmodule

@@ sv/deq_chk.sv @@
// Port-level checker for the bounded deque, bound to the top level.
module deq_chk
    import deq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_func,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ok,
    input logic        o_found,
    input logic [4:0]  o_count
);

    // Never take an item while a result is stuck in the output register.
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!o_valid || i_ready))
        else $error("input ready while output register is blocked");

    // A push or pop yields its result on the next cycle.
    a_push_pop_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_func != FUNC_SEARCH)) |=> o_valid)
        else $error("push/pop result not presented on next cycle");

    // A result is either a push/pop outcome or a search hit, never both.
    a_ok_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ok && o_found))
        else $error("ok and found both set");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ok) && $stable(o_found)
                                   && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind bounded_deque_with_search_unit deq_chk u_deq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_func  (i_func),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_ok    (o_ok),
    .o_found (o_found),
    .o_count (o_count)
);

@@ dv/bounded_deque_with_search_unit_tb.sv @@
// Self-checking testbench for the bounded deque with membership search.
`timescale 1ns / 100ps

module bounded_deque_with_search_unit_tb;
    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_OPS = 650;
    localparam int QUIET_TAIL = 100;
    localparam int LONG_HOLD_CYCLES = 300;

    // Codes the block treats as no operation.
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    typedef struct packed {
        logic       ok;
        logic       found;
        logic [4:0] count;
    } t_deque_outcome;

    // Shadow copy of the deque: predicts the outcome of every transfer taken
    // by the block and checks each result transfer against the oldest one.
    class t_deque_shadow;
        logic [31:0]    slots [DEPTH];
        logic [3:0]     head;
        logic [4:0]     fill;
        t_deque_outcome outcomes_due [$];
        int             fail_count;

        function new();
            head = '0;
            fill = '0;
            fail_count = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void record_op(logic [2:0] f, logic [31:0] v);
            t_deque_outcome o;
            logic [3:0]     idx;
            o = '0;
            case (f)
                FUNC_PUSH_FRONT: begin
                    if (fill < 5'(DEPTH)) begin
                        head = head - 4'd1;
                        slots[head] = v;
                        fill++;
                        o.ok = 1'b1;
                    end
                end
                FUNC_PUSH_BACK: begin
                    if (fill < 5'(DEPTH)) begin
                        idx = head + fill[3:0];
                        slots[idx] = v;
                        fill++;
                        o.ok = 1'b1;
                    end
                end
                FUNC_POP_FRONT: begin
                    if (fill > 0) begin
                        head = head + 4'd1;
                        fill--;
                        o.ok = 1'b1;
                    end
                end
                FUNC_POP_BACK: begin
                    if (fill > 0) begin
                        fill--;
                        o.ok = 1'b1;
                    end
                end
                FUNC_SEARCH: begin
                    for (int i = 0; i < int'(fill); i++) begin
                        idx = head + 4'(i);
                        if (slots[idx] == v) o.found = 1'b1;
                    end
                end
                default: ;
            endcase
            o.count = fill;
            outcomes_due.push_back(o);
        endfunction

        function void compare_result(logic ok, logic found, logic [4:0] count);
            t_deque_outcome exp_o;
            if (outcomes_due.size() == 0) begin
                $error("result transfer with no outcome pending: ok=%0d found=%0d count=%0d",
                       ok, found, count);
                fail_count++;
                return;
            end
            exp_o = outcomes_due.pop_front();
            if (ok !== exp_o.ok) begin
                $error("ok mismatch: expected %0d, actual %0d", exp_o.ok, ok);
                fail_count++;
            end
            if (found !== exp_o.found) begin
                $error("found mismatch: expected %0d, actual %0d", exp_o.found, found);
                fail_count++;
            end
            if (count !== exp_o.count) begin
                $error("count mismatch: expected %0d, actual %0d", exp_o.count, count);
                fail_count++;
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        // Return one of the stored values, for searches that should hit.
        function logic [31:0] any_stored();
            logic [3:0] idx;
            idx = head + 4'($urandom_range(0, int'(fill) - 1));
            return slots[idx];
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_func = '0;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_ok;
    logic               o_found;
    logic [4:0]         o_count;

    t_deque_shadow tracker = new();

    // Set by the stimulus; the receiver picks it up and counts the hold-off.
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int cycle_count = 0;

    bounded_deque_with_search_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_func (i_func),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_ok   (o_ok),
        .o_found(o_found),
        .o_count(o_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: check each result transfer, then choose the next ready level.
    // Random stall bursts, plus one long hold-off so the block backs up and
    // drops its input ready while the sender keeps offering.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                tracker.compare_result(o_ok, o_found, o_count);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one operation and hold it until the block takes it. Valid stays
    // high on return so back-to-back transfers need no extra edge.
    task automatic send_op(input logic [2:0] f, input logic [31:0] v);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_value <= v;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        tracker.record_op(f, v);
    endtask

    // Mix extremes and a small pool of repeats so searches hit duplicates.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // Choose an operation; the mode biases toward filling, draining or
    // an even mix so both the full and the empty boundaries get hit often.
    task automatic send_random(input int mode);
        int          roll;
        logic [2:0]  f;
        logic [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            f = 3'($urandom_range(5, 7));
        end else if (roll < 25) begin
            f = FUNC_SEARCH;
        end else if (mode == 0) begin
            f = (roll < 85) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 3));
        end else if (mode == 1) begin
            f = (roll < 85) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 1));
        end else begin
            f = 3'($urandom_range(0, 3));
        end
        if (f == FUNC_SEARCH && tracker.fill > 0 && $urandom_range(0, 9) < 6) begin
            v = tracker.any_stored();
        end else begin
            v = pick_value();
        end
        send_op(f, v);
    endtask

    initial begin
        int mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extremes, spare codes, full queue.
        send_op(FUNC_POP_FRONT, 32'h0);
        send_op(FUNC_POP_BACK, 32'h0);
        send_op(FUNC_SEARCH, 32'h0);
        send_op(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(FUNC_PUSH_BACK, 32'h8000_0000);
        send_op(FUNC_SEARCH, 32'h8000_0000);
        send_op(FUNC_SPARE_5, $urandom());
        send_op(FUNC_SPARE_6, $urandom());
        send_op(FUNC_SPARE_7, $urandom());
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_op((i % 2 == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, $urandom());
        end
        send_op(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(FUNC_PUSH_BACK, 32'h0);
        send_op(FUNC_SEARCH, 32'h8000_0000);
        send_op(FUNC_SEARCH, 32'h7FFF_FFFF);

        // Random: switch bias every few dozen transfers.
        mode = 1;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            if (n == 250) hold_request = 1'b1;
            if (n == RANDOM_OPS - QUIET_TAIL) quiet = 1'b1;
            send_random(mode);
        end
        i_valid <= 1'b0;

        // Drain, then give a late or stray result time to show up.
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/deq_pkg.sv
sv/deq_ram.sv
sv/bounded_deque_with_search_unit.sv
sv/deq_chk.sv
dv/bounded_deque_with_search_unit_tb.sv
